FILE: design/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
package ptts_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int OP_W           = 3;
    localparam int ID_W           = 3;
    localparam int TIME_W         = 16;
    localparam int MASK_W         = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_DELETE  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_INACTIVE  = 2'd0,
        ST_READY     = 2'd1,
        ST_SUSPENDED = 2'd2
    } slot_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } sched_state_t;

    // Slot command towards the status table.
    typedef struct packed {
        logic    valid;
        opcode_t op;
    } status_cmd_t;

    // Result of the shared countdown unit for one slot.
    typedef struct packed {
        logic              write;
        logic              fire;
        logic [TIME_W-1:0] count;
    } slot_upd_t;

endpackage

FILE: design/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler: sequencer and output register.
//
// One request per accepted input item (in_valid high, in_stall low at a rising edge).
// Create, suspend, resume and delete act on the slot named by task_id and
// give no result. Unknown opcodes and slot numbers at or above SLOT_COUNT
// are dropped.
// A tick walks the slot table one slot per cycle through a single shared
// countdown unit: slot k is read from the period/countdown RAM while slot k-1
// is updated and written back. Slot 0 is already on the read port when the
// tick is taken, so the walk starts at once. in_stall stays high through the
// walk, and the tick's fire_mask is offered on out_valid at the edge that
// ends the walk.
// The result sits in an output register. If the receiver raises out_stall,
// the block keeps taking non-tick requests; a further tick completes its walk
// and then waits until the register is free before returning to idle.
// Reset (rst_n low, asynchronous) marks every slot inactive and empties the
// output register; the RAM is not cleared, as a slot's entry is only used after a
// create has written it.
module periodic_task_tick_scheduler #(
    parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ptts_pkg::OP_W-1:0]     opcode,
    input  logic [ptts_pkg::ID_W-1:0]     task_id,
    input  logic [ptts_pkg::TIME_W-1:0]   period,
    input  logic [ptts_pkg::TIME_W-1:0]   first_delay,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ptts_pkg::MASK_W-1:0]   fire_mask
);
    import ptts_pkg::*;

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EXT_W   = 7;
    localparam int RAM_W   = 2 * TIME_W;
    localparam int BIT_W   = $clog2(MASK_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    sched_state_t      state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] fire_mask_reg, fire_mask_next;

    logic              accept_in;
    logic              is_tick;
    logic [EXT_W-1:0]  id_ext;
    logic              id_ok;
    logic [IDX_W-1:0]  cmd_idx;
    logic              out_free;
    logic              load_out;
    logic [MASK_W-1:0] out_mask;
    logic [EXT_W-1:0]  sweep_ext;
    logic [MASK_W-1:0] fire_bit;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]  ram_rdata;

    status_cmd_t       st_cmd;
    logic              sweep_ready;
    slot_upd_t         upd;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign is_tick   = (opcode == OP_TICK);
    assign id_ext    = EXT_W'(task_id);
    assign id_ok     = (id_ext < EXT_W'(SLOT_COUNT));
    assign cmd_idx   = id_ext[IDX_W-1:0];
    assign out_free  = !out_valid_reg || !out_stall;

    // Only slots below eight have a bit in the mask.
    assign sweep_ext = EXT_W'(idx_reg);
    assign fire_bit  = (upd.fire && (sweep_ext < EXT_W'(MASK_W)))
                       ? (MASK_W'(1) << sweep_ext[BIT_W-1:0]) : '0;

    always_comb
    begin
        st_cmd.valid = accept_in && !is_tick && id_ok;
        st_cmd.op    = opcode_t'(opcode);
    end

    ptts_status #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_status (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (st_cmd),
        .cmd_idx     (cmd_idx),
        .sweep_idx   (idx_reg),
        .sweep_ready (sweep_ready)
    );

    // Each entry holds {period, countdown}.
    ptts_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptts_slot_alu u_alu (
        .ready  (sweep_ready && (state_reg == S_RUN)),
        .period (ram_rdata[RAM_W-1:TIME_W]),
        .count  (ram_rdata[TIME_W-1:0]),
        .upd    (upd)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in && is_tick)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control.
    always_comb
    begin
        idx_next  = idx_reg;
        mask_next = mask_reg;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {ram_rdata[RAM_W-1:TIME_W], upd.count};
        ram_raddr = '0;
        load_out  = 1'b0;
        out_mask  = mask_reg;
        case (state_reg)
            S_IDLE:
            begin
                // Keep slot 0 on the read port so a tick starts at once.
                if (accept_in && is_tick)
                begin
                    idx_next  = '0;
                    mask_next = '0;
                end
                if (accept_in && (opcode == OP_CREATE) && id_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cmd_idx;
                    ram_wdata = {period, first_delay};
                end
            end
            S_RUN:
            begin
                // Write back slot idx, fetch the one after it.
                ram_we    = upd.write;
                mask_next = mask_reg | fire_bit;
                idx_next  = IDX_W'(idx_reg + 1'b1);
                ram_raddr = (idx_reg == LAST_IDX) ? '0 : IDX_W'(idx_reg + 1'b1);
                if (idx_reg == LAST_IDX)
                begin
                    load_out = out_free;
                    out_mask = mask_next;
                end
            end
            S_HOLD:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        fire_mask_next = fire_mask_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            fire_mask_next = out_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        mask_reg      <= mask_next;
        fire_mask_reg <= fire_mask_next;
    end

    assign out_valid = out_valid_reg;
    assign fire_mask = fire_mask_reg;

endmodule

FILE: design/ptts_ram.sv
// Generic simple dual-port RAM with registered read data.
module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ptts_status.sv
// Per-slot status flip-flops: create, suspend, resume and delete updates.
module ptts_status #(
    parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptts_pkg::status_cmd_t cmd,
    input  logic [IDX_W-1:0]      cmd_idx,
    input  logic [IDX_W-1:0]      sweep_idx,
    output logic                  sweep_ready
);
    import ptts_pkg::*;

    slot_status_t status_reg  [SLOT_COUNT];
    slot_status_t status_next [SLOT_COUNT];

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            status_next[i] = status_reg[i];
            if (cmd.valid && (cmd_idx == IDX_W'(i)))
            begin
                case (cmd.op)
                    OP_CREATE:
                    begin
                        status_next[i] = ST_READY;
                    end
                    OP_SUSPEND:
                    begin
                        if (status_reg[i] != ST_INACTIVE)
                        begin
                            status_next[i] = ST_SUSPENDED;
                        end
                    end
                    OP_RESUME:
                    begin
                        if (status_reg[i] != ST_INACTIVE)
                        begin
                            status_next[i] = ST_READY;
                        end
                    end
                    OP_DELETE:
                    begin
                        status_next[i] = ST_INACTIVE;
                    end
                    default:
                    begin
                        status_next[i] = status_reg[i];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                status_reg[i] <= ST_INACTIVE;
            end
        end
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                status_reg[i] <= status_next[i];
            end
        end
    end

    assign sweep_ready = (status_reg[sweep_idx] == ST_READY);

endmodule

FILE: design/ptts_slot_alu.sv
// Shared countdown unit: compare with zero, then decrement the count or reload it with period minus one.
module ptts_slot_alu (
    input  logic                            ready,
    input  logic [ptts_pkg::TIME_W-1:0]     period,
    input  logic [ptts_pkg::TIME_W-1:0]     count,
    output ptts_pkg::slot_upd_t             upd
);
    import ptts_pkg::*;

    logic              at_zero;
    logic [TIME_W-1:0] operand;

    assign at_zero = (count == '0);
    // Reload wraps: a zero period gives all ones.
    assign operand = at_zero ? period : count;

    always_comb
    begin
        upd.write = ready;
        upd.fire  = ready && at_zero;
        upd.count = operand - TIME_W'(1);
    end

endmodule
